### design/ctl_pkg.sv
// Package with types, codes and tables shared by the C token lexer.
`default_nettype none
package ctl_pkg;

  localparam int unsigned KeywordCount = 32;
  localparam int unsigned MaxKeywordLen = 8;
  localparam int unsigned KwTableSize = 32;
  localparam int unsigned RunW = 8;

  typedef enum logic [4:0] {
    K_STRING = 5'd0, K_NUMBER = 5'd1, K_KEYWORD = 5'd2, K_IDENT = 5'd3,
    K_SEP = 5'd4, K_GTE = 5'd5, K_GT = 5'd6, K_EQ = 5'd7, K_NEQ = 5'd8,
    K_LTE = 5'd9, K_LT = 5'd10, K_NOT = 5'd11, K_ASSIGN = 5'd12,
    K_LAND = 5'd13, K_BAND = 5'd14, K_LOR = 5'd15, K_BOR = 5'd16,
    K_XOR = 5'd17, K_INC = 5'd18, K_DEC = 5'd19, K_ADD = 5'd20,
    K_SUB = 5'd21, K_MUL = 5'd22, K_DIV = 5'd23, K_MOD = 5'd24,
    K_UNKNOWN = 5'd25
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_row;
    logic [15:0] start_col;
    logic [7:0]  tok_len;
    logic        last;
  } out_item_t;

  typedef logic [MaxKeywordLen-1:0][7:0] word_t;

  // Keyword table, byte 0 first, zero padded, with length.
  function automatic word_t kw_text(input int unsigned idx);
    word_t w;
    string s;
    w = '0;
    case (idx)
      0: s = "auto";      1: s = "break";    2: s = "case";     3: s = "char";
      4: s = "const";     5: s = "continue"; 6: s = "default";  7: s = "do";
      8: s = "double";    9: s = "else";     10: s = "enum";    11: s = "extern";
      12: s = "float";    13: s = "for";     14: s = "goto";    15: s = "if";
      16: s = "int";      17: s = "long";    18: s = "register"; 19: s = "return";
      20: s = "short";    21: s = "signed";  22: s = "sizeof";  23: s = "static";
      24: s = "struct";   25: s = "switch";  26: s = "typedef"; 27: s = "union";
      28: s = "unsigned"; 29: s = "void";    30: s = "volatile"; 31: s = "while";
      default: s = "";
    endcase
    for (int i = 0; i < s.len() && i < MaxKeywordLen; i++) w[i] = s[i];
    return w;
  endfunction

  function automatic int unsigned kw_len(input int unsigned idx);
    word_t w;
    int unsigned n;
    w = kw_text(idx);
    n = 0;
    for (int i = 0; i < MaxKeywordLen; i++) if (w[i] != 8'd0 && n == i) n = i + 1;
    return n;
  endfunction

  function automatic kind_e single_kind(input logic [7:0] p);
    case (p)
      ">": return K_GT;
      "<": return K_LT;
      "!": return K_NOT;
      "=": return K_ASSIGN;
      "&": return K_BAND;
      "|": return K_BOR;
      "+": return K_ADD;
      "-": return K_SUB;
      "^": return K_XOR;
      "*": return K_MUL;
      "/": return K_DIV;
      "%": return K_MOD;
      default: return K_UNKNOWN;
    endcase
  endfunction

endpackage
`default_nettype wire

### design/c_token_lexer.sv
// Top level of the streaming C token lexer.
// The lexer takes one source byte per transaction on the input channel
// (in_valid_i / in_stall_o / in_data_i) and emits C tokens on the output
// channel (out_valid_o / out_stall_i / out_data_o). Each token carries its
// kind, the row and column of its first byte and its length.
// One input byte may produce zero, one or two tokens; the last token of a
// byte carries last = 1. The work for a byte is done combinationally: the
// tokens it yields appear in a four-entry output buffer in the cycle after
// acceptance. A byte is taken in every cycle while at most two tokens are
// held, so the buffer always has room for the two a byte can yield.
// Throughput is one byte per cycle when the receiver does not stall and the
// bytes yield no more than one token each on average; the output drains
// one token per cycle.
// When the receiver stalls, held tokens stay stable and the input is
// stalled once more than two tokens are held.
// An end-of-input marker flushes the pending token and returns the
// position to row 1, column 0.
// Reset clears the lexer mode, position and the output buffer.
`default_nettype none
module c_token_lexer import ctl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);
  typedef enum logic [2:0] {
    M_IDLE = 3'd0, M_STR = 3'd1, M_NUM = 3'd2, M_WORD = 3'd3, M_OP = 3'd4
  } mode_e;

  logic [2:0]  mode_q, mode_d;
  logic [7:0]  pend_q, pend_d;
  word_t       word_q, word_d;
  logic [7:0]  run_q, run_d;
  logic [15:0] trow_q, trow_d, tcol_q, tcol_d, crow_q, crow_d, ccol_q, ccol_d;

  // Output buffer: up to four entries to keep one-per-cycle with stalls.
  out_item_t   buf_q [4];
  logic [1:0]  rd_q;
  logic [2:0]  cnt_q;

  logic        kw_hit;
  ctl_kw_match u_kw (.word_i(word_q), .len_i(run_q), .hit_o(kw_hit));

  logic        acc;
  out_item_t   e0, e1;
  logic [1:0]  ne;

  assign in_stall_o = (cnt_q > 3'd2);
  assign acc = in_valid_i && !in_stall_o;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction
  function automatic logic is_alp(input logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic        take;
    logic        fl;
    out_item_t   ft, it;
    logic        itv, ws;
    logic [4:0]  pk;
    logic [15:0] nrow, ncol;
    c = in_data_i.ch;
    mode_d = mode_q; pend_d = pend_q; word_d = word_q; run_d = run_q;
    trow_d = trow_q; tcol_d = tcol_q; crow_d = crow_q; ccol_d = ccol_q;
    take = 1'b0; fl = 1'b0; itv = 1'b0; ws = 1'b0;
    ft = '0; it = '0;
    // Flush token of the pending state.
    ft.start_row = trow_q; ft.start_col = tcol_q; ft.tok_len = run_q;
    case (mode_q)
      M_STR:  ft.kind = K_STRING;
      M_NUM:  ft.kind = K_NUMBER;
      M_WORD: ft.kind = (run_q <= 8'(MaxKeywordLen) && kw_hit) ? K_KEYWORD : K_IDENT;
      M_OP:   begin ft.kind = single_kind(pend_q); ft.tok_len = 8'd1; end
      default: ft.kind = K_UNKNOWN;
    endcase
    pk = 5'h1f;
    if (c == "=") begin
      if (pend_q == ">") pk = K_GTE;
      else if (pend_q == "=") pk = K_EQ;
      else if (pend_q == "!") pk = K_NEQ;
      else if (pend_q == "<") pk = K_LTE;
    end
    if (pend_q == "&" && c == "&") pk = K_LAND;
    if (pend_q == "|" && c == "|") pk = K_LOR;
    if (pend_q == "+" && c == "+") pk = K_INC;
    if (pend_q == "-" && c == "-") pk = K_DEC;
    nrow = (c == 8'h0a) ? ((crow_q != 16'hffff) ? crow_q + 16'd1 : crow_q) : crow_q;
    ncol = (c == 8'h0a) ? 16'd0 : ((ccol_q != 16'hffff) ? ccol_q + 16'd1 : ccol_q);
    if (in_data_i.end_mark) begin
      fl = (mode_q == M_STR || mode_q == M_NUM || mode_q == M_WORD || mode_q == M_OP);
      mode_d = M_IDLE; run_d = '0; pend_d = '0;
      trow_d = 16'd1; tcol_d = '0; crow_d = 16'd1; ccol_d = '0;
    end else begin
      case (mode_q)
        M_STR: begin
          run_d = (run_q != 8'hff) ? run_q + 8'd1 : run_q;
          crow_d = nrow; ccol_d = ncol;
          if (c == "\"") begin
            fl = 1'b1; ft.tok_len = run_d; mode_d = M_IDLE; run_d = '0;
          end
        end
        M_NUM: begin
          if (is_dig(c)) begin
            run_d = (run_q != 8'hff) ? run_q + 8'd1 : run_q;
            crow_d = nrow; ccol_d = ncol;
          end else begin fl = 1'b1; take = 1'b1; end
        end
        M_WORD: begin
          if (is_dig(c) || is_alp(c)) begin
            if (run_q < 8'(MaxKeywordLen)) word_d[run_q[2:0]] = c;
            run_d = (run_q != 8'hff) ? run_q + 8'd1 : run_q;
            crow_d = nrow; ccol_d = ncol;
          end else begin fl = 1'b1; take = 1'b1; end
        end
        M_OP: begin
          if (pk != 5'h1f) begin
            crow_d = nrow; ccol_d = ncol;
            fl = 1'b1; ft.kind = pk; ft.tok_len = 8'd2;
            mode_d = M_IDLE; run_d = '0;
          end else begin fl = 1'b1; take = 1'b1; end
        end
        default: take = 1'b1;
      endcase
    end
    if (take) begin
      mode_d = M_IDLE; run_d = '0;
      crow_d = nrow; ccol_d = ncol;
      ws = (c == 8'h0a || c == " " || c == 8'h09 || c == 8'h0d);
      if (!ws) begin
        it.start_row = crow_q; it.start_col = ccol_q; it.tok_len = 8'd1;
        if (c == "\"") begin
          mode_d = M_STR; trow_d = crow_q; tcol_d = ccol_q; run_d = 8'd1;
        end else if (is_dig(c)) begin
          mode_d = M_NUM; trow_d = crow_q; tcol_d = ccol_q; run_d = 8'd1;
        end else if (is_alp(c)) begin
          mode_d = M_WORD; trow_d = crow_q; tcol_d = ccol_q; run_d = 8'd1;
          word_d[0] = c;
        end else if (c == ">" || c == "<" || c == "=" || c == "!" || c == "&" ||
                     c == "|" || c == "+" || c == "-") begin
          mode_d = M_OP; trow_d = crow_q; tcol_d = ccol_q; run_d = 8'd1;
          pend_d = c;
        end else if (c == "(" || c == ")" || c == "{" || c == "}" || c == "[" ||
                     c == "]" || c == "," || c == ";") begin
          itv = 1'b1; it.kind = K_SEP;
        end else begin
          itv = 1'b1; it.kind = single_kind(c);
        end
      end
    end
    ft.last = !itv; it.last = 1'b1;
    e0 = fl ? ft : it;
    e1 = it;
    ne = {1'b0, fl} + {1'b0, itv};
  end

  logic pop;
  assign pop = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pend_q <= '0; run_q <= '0;
      trow_q <= 16'd1; tcol_q <= '0; crow_q <= 16'd1; ccol_q <= '0;
      rd_q <= '0; cnt_q <= '0;
    end else begin
      logic [1:0] wp;
      logic [1:0] push;
      wp = rd_q + cnt_q[1:0];
      push = acc ? ne : 2'd0;
      if (acc) begin
        mode_q <= mode_d; pend_q <= pend_d; run_q <= run_d;
        trow_q <= trow_d; tcol_q <= tcol_d; crow_q <= crow_d; ccol_q <= ccol_d;
      end
      if (push != 2'd0) buf_q[wp] <= e0;
      if (push == 2'd2) buf_q[wp + 2'd1] <= e1;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) word_q <= word_d;
  end
endmodule
`default_nettype wire

### design/ctl_kw_match.sv
// Parallel keyword compare of the buffered word.
`default_nettype none
module ctl_kw_match import ctl_pkg::*; (
  input  wire word_t      word_i,
  input  wire logic [7:0] len_i,
  output logic            hit_o
);
  always_comb begin
    word_t kw;
    logic  ok;
    hit_o = 1'b0;
    for (int i = 0; i < KeywordCount && i < KwTableSize; i++) begin
      kw = kw_text(i);
      ok = ({24'd0, len_i} == 32'(kw_len(i)));
      for (int j = 0; j < MaxKeywordLen; j++)
        if (j < kw_len(i) && word_i[j] != kw[j]) ok = 1'b0;
      if (ok) hit_o = 1'b1;
    end
  end
endmodule
`default_nettype wire

### design/ctl_checker.sv
// Port-level checker for the C token lexer, bound to the top level.
`default_nettype none
module ctl_checker import ctl_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled token changed");
  a_len_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.tok_len != 8'd0)
    else $error("zero length token");
  a_row_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.start_row != 16'd0)
    else $error("row zero token");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind <= K_UNKNOWN)
    else $error("bad kind");
  a_op_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind >= K_GTE && out_data_o.kind != K_UNKNOWN
      |-> out_data_o.tok_len <= 8'd2)
    else $error("operator too long");
endmodule

bind c_token_lexer ctl_checker u_ctl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o));
`default_nettype wire
